>>> rtl/dsba_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Shared widths, operation and status codes, register indexes and the
// bitmap memory command type.
// ----------------------------------------------------------------------------
package dsba_pkg;

	// Field widths.
	localparam int OP_W      = 3;
	localparam int HANDLE_W  = 48;
	localparam int STRIDE_W  = 13;
	localparam int SLOT_W    = 11;
	localparam int PSLOT_W   = 10;
	localparam int ST_W      = 2;
	localparam int CFG_IDX_W = 3;

	// Bitmap word organization.
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;
	localparam int WI_W   = SLOT_W - BIT_W;
	localparam int NW_W   = WI_W + 1;

	// Largest slot count that the count register can express.
	localparam int SLOT_LIMIT = (1 << SLOT_W) - 1;

	// Offset and product width: stride times slot count stays below this.
	localparam int DIV_W  = STRIDE_W + SLOT_W;
	localparam int STEP_W = 4;

	// Default bitmap depth.
	localparam int MAX_SLOTS_DEF = 1024;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
	localparam logic [OP_W-1:0] OP_RESERVE = 3'd2;
	localparam logic [OP_W-1:0] OP_FIND_HI = 3'd3;
	localparam logic [OP_W-1:0] OP_INDEX   = 3'd4;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DESC_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_CNT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHADER_VIS = 3'd4;

	// Configuration reset values.
	localparam logic [STRIDE_W-1:0] DESC_SIZE_RST = 13'd32;
	localparam logic [SLOT_W-1:0]   SLOT_CNT_RST  = 11'd1024;

	// Bitmap memory command.
	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

endpackage

>>> rtl/dsba_bitmap_mem.sv
// ----------------------------------------------------------------------------
// Slot bitmap memory
// Simple dual-port word memory with a registered read and a clearing
// sweep after reset that marks every slot free.
// ----------------------------------------------------------------------------
module dsba_bitmap_mem #(
	parameter int WORDS = dsba_pkg::MAX_SLOTS_DEF / dsba_pkg::WORD_W,
	parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dsba_pkg::mem_cmd_t          cmd,
	input  logic [AW-1:0]               raddr,
	input  logic [AW-1:0]               waddr,
	input  logic [dsba_pkg::WORD_W-1:0] wdata,
	output logic [dsba_pkg::WORD_W-1:0] rdata,
	output logic                        ready
);

	logic [dsba_pkg::WORD_W-1:0] mem [WORDS];
	logic [dsba_pkg::WORD_W-1:0] rdata_q;
	logic                        clr_q;
	logic [AW-1:0]               clr_addr_q;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [dsba_pkg::WORD_W-1:0] wr_data;

	// Clearing sweep: one word per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(WORDS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// The sweep owns the write port until it is done.
	always_comb begin
		wr_en   = clr_q | cmd.wr;
		wr_addr = clr_q ? clr_addr_q : waddr;
		wr_data = clr_q ? '0 : wdata;
	end

	// Storage with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
	assign ready = ~clr_q;

endmodule

>>> rtl/dsba_stride_div.sv
// ----------------------------------------------------------------------------
// Stride divider
// Restoring divider, one quotient bit per cycle, that turns a byte offset
// into a slot number. The offset must be below the stride times 2^SLOT_W.
// ----------------------------------------------------------------------------
module dsba_stride_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dsba_pkg::DIV_W-1:0]  dividend,
	input  logic [dsba_pkg::STRIDE_W-1:0] divisor,
	output logic                        done,
	output logic [dsba_pkg::SLOT_W-1:0] quotient
);

	logic [dsba_pkg::STEP_W-1:0] step_q;
	logic                        done_q;
	logic [dsba_pkg::DIV_W-1:0]  rem_q;
	logic [dsba_pkg::DIV_W-1:0]  dsr_q;
	logic [dsba_pkg::SLOT_W-1:0] quo_q;
	logic                        ge;

	assign ge = rem_q >= dsr_q;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= dsba_pkg::STEP_W'(dsba_pkg::SLOT_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				if (step_q == dsba_pkg::STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Trial subtraction of the shifted stride, most significant bit first.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= dsba_pkg::DIV_W'({divisor, {(dsba_pkg::SLOT_W - 1){1'b0}}});
			quo_q <= '0;
		end else if (step_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			quo_q <= {quo_q[dsba_pkg::SLOT_W-2:0], ge};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/descriptor_slot_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Descriptor slot bitmap allocator
// Keeps one used bit per descriptor slot in a word memory and serves
// allocate, free, reserve, find-highest and index requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge with start high and busy low. The
//   result shows on status, slot_out, cpu_handle and gpu_handle for exactly
//   one cycle with done high; there is no back-pressure on results.
//   Configuration is written through cfg_we, cfg_idx and cfg_data while no
//   request is in flight.
// Request flow (default 1024 slots, 32-bit bitmap words):
//   Allocate scans the bitmap words from the lowest up, marks the first
//   free slot, writes its word back and adds the slot times the stride to
//   the bases. Find-highest scans from the highest word down and returns
//   the slot it finds without the write-back and address states. A full
//   heap, like an empty one, returns full status. Free and index pass a
//   range check and then the stride divider, which produces one slot bit
//   per cycle; a handle outside the heap returns from the range check.
//   Reserve returns from dispatch when the slot is outside the heap, as
//   does an unknown code. busy falls with done, so the next request can be
//   taken at the edge that ends the result cycle; one request is in flight at a time.
// Reset:
//   Configuration returns to its reset values, and the bitmap is swept to
//   all free, one word per cycle, with the depth held to 2047 slots. busy
//   stays high during the sweep.
// ----------------------------------------------------------------------------
module descriptor_slot_bitmap_allocator #(
	parameter int MAX_SLOTS = dsba_pkg::MAX_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	output logic                           done,
	input  logic [dsba_pkg::OP_W-1:0]      op,
	input  logic [dsba_pkg::HANDLE_W-1:0]  handle,
	input  logic [dsba_pkg::PSLOT_W-1:0]   slot_in,
	output logic [dsba_pkg::ST_W-1:0]      status,
	output logic [dsba_pkg::PSLOT_W-1:0]   slot_out,
	output logic [dsba_pkg::HANDLE_W-1:0]  cpu_handle,
	output logic [dsba_pkg::HANDLE_W-1:0]  gpu_handle,
	input  logic                           cfg_we,
	input  logic [dsba_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [dsba_pkg::HANDLE_W-1:0]  cfg_data
);

	localparam int USABLE = (MAX_SLOTS < dsba_pkg::SLOT_LIMIT) ?
		MAX_SLOTS : dsba_pkg::SLOT_LIMIT;
	localparam int WORDS  = (USABLE + dsba_pkg::WORD_W - 1) / dsba_pkg::WORD_W;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;

	localparam int SL_W = dsba_pkg::SLOT_W;
	localparam int HW   = dsba_pkg::HANDLE_W;
	localparam int WW   = dsba_pkg::WORD_W;
	localparam int DW   = dsba_pkg::DIV_W;

	// Controller states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_WB     = 4'd3;
	localparam logic [3:0] S_ADDR   = 4'd4;
	localparam logic [3:0] S_RCHK   = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_RMW_RD = 4'd7;
	localparam logic [3:0] S_RMW_WR = 4'd8;

	// Configuration registers.
	logic [HW-1:0]                 cpu_base_q;
	logic [HW-1:0]                 gpu_base_q;
	logic [dsba_pkg::STRIDE_W-1:0] desc_size_q;
	logic [SL_W-1:0]               slot_cnt_q;
	logic                          shader_vis_q;

	// Request and working registers.
	logic [3:0]                    state_q;
	logic [dsba_pkg::OP_W-1:0]     op_q;
	logic [HW-1:0]                 handle_q;
	logic [dsba_pkg::PSLOT_W-1:0]  slot_in_q;
	logic                          scan_up_q;
	logic [dsba_pkg::WI_W-1:0]     scan_wi_q;
	logic [dsba_pkg::NW_W-1:0]     scan_left_q;
	logic                          pend_s1;
	logic [dsba_pkg::WI_W-1:0]     pend_wi_s1;
	logic [AW-1:0]                 wa_q;
	logic [dsba_pkg::BIT_W-1:0]    bit_q;
	logic                          set_q;
	logic [WW-1:0]                 wword_q;
	logic [SL_W-1:0]               slot_q;
	logic [DW-1:0]                 prod_q;
	logic                          lt_q;
	logic [HW-1:0]                 off_q;
	logic [DW-1:0]                 lim_q;
	logic                          div_start_q;

	// Result registers.
	logic                          done_q;
	logic [dsba_pkg::ST_W-1:0]     status_q;
	logic [dsba_pkg::PSLOT_W-1:0]  slot_out_q;
	logic [HW-1:0]                 cpu_q;
	logic [HW-1:0]                 gpu_q;

	// Derived values and memory port.
	logic [dsba_pkg::STRIDE_W-1:0] stride;
	logic [SL_W-1:0]               n;
	logic [dsba_pkg::NW_W-1:0]     nw;
	logic [HW-1:0]                 base;
	logic [WW-1:0]                 mask;
	logic [WW-1:0]                 free_bits;
	logic                          lo_found;
	logic [dsba_pkg::BIT_W-1:0]    lo_bit;
	logic                          hi_found;
	logic [dsba_pkg::BIT_W-1:0]    hi_bit;
	logic                          hit;
	logic                          scan_issue;
	logic [WW-1:0]                 bit_mask;
	dsba_pkg::mem_cmd_t            mem_cmd;
	logic [AW-1:0]                 mem_raddr;
	logic [WW-1:0]                 mem_wdata;
	logic [WW-1:0]                 mem_rdata;
	logic                          mem_ready;
	logic                          div_done;
	logic [SL_W-1:0]               div_quo;

	// A zero stride counts as one; the slot count is capped by the bitmap depth.
	always_comb begin
		stride = (desc_size_q == '0) ? dsba_pkg::STRIDE_W'(1) : desc_size_q;
		n      = (32'(slot_cnt_q) < MAX_SLOTS) ? slot_cnt_q : SL_W'(MAX_SLOTS);
		nw     = dsba_pkg::NW_W'((12'(n) + 12'(WW - 1)) >> dsba_pkg::BIT_W);
		base   = (op_q == dsba_pkg::OP_FREE) ? cpu_base_q : gpu_base_q;
	end

	// Slots of the word under test that lie inside the heap.
	always_comb begin
		if (pend_wi_s1 < n[SL_W-1:dsba_pkg::BIT_W]) begin
			mask = '1;
		end else if (pend_wi_s1 == n[SL_W-1:dsba_pkg::BIT_W]) begin
			mask = (WW'(1) << n[dsba_pkg::BIT_W-1:0]) - WW'(1);
		end else begin
			mask = '0;
		end
		free_bits = ~mem_rdata & mask;
	end

	// Lowest and highest free slot in the word under test.
	always_comb begin
		lo_found = 1'b0;
		lo_bit   = '0;
		hi_found = 1'b0;
		hi_bit   = '0;
		for (int b = WW - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				lo_found = 1'b1;
				lo_bit   = dsba_pkg::BIT_W'(b);
			end
		end
		for (int b = 0; b < WW; b++) begin
			if (free_bits[b]) begin
				hi_found = 1'b1;
				hi_bit   = dsba_pkg::BIT_W'(b);
			end
		end
		hit = pend_s1 & (scan_up_q ? lo_found : hi_found);
	end

	// Bitmap memory port.
	always_comb begin
		scan_issue  = (state_q == S_SCAN) && (scan_left_q != '0);
		bit_mask    = WW'(1) << bit_q;
		mem_cmd.rd  = scan_issue || (state_q == S_RMW_RD);
		mem_cmd.wr  = (state_q == S_WB) || (state_q == S_RMW_WR);
		mem_raddr   = (state_q == S_SCAN) ? AW'(scan_wi_q) : wa_q;
		if (state_q == S_WB) begin
			mem_wdata = wword_q;
		end else if (set_q) begin
			mem_wdata = mem_rdata | bit_mask;
		end else begin
			mem_wdata = mem_rdata & ~bit_mask;
		end
	end

	dsba_bitmap_mem #(
		.WORDS (WORDS),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mem_cmd),
		.raddr  (mem_raddr),
		.waddr  (wa_q),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata),
		.ready  (mem_ready)
	);

	dsba_stride_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (off_q[DW-1:0]),
		.divisor  (stride),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_base_q   <= '0;
			gpu_base_q   <= '0;
			desc_size_q  <= dsba_pkg::DESC_SIZE_RST;
			slot_cnt_q   <= dsba_pkg::SLOT_CNT_RST;
			shader_vis_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dsba_pkg::REG_CPU_BASE:   cpu_base_q   <= cfg_data;
				dsba_pkg::REG_GPU_BASE:   gpu_base_q   <= cfg_data;
				dsba_pkg::REG_DESC_SIZE:  desc_size_q  <= cfg_data[dsba_pkg::STRIDE_W-1:0];
				dsba_pkg::REG_SLOT_CNT:   slot_cnt_q   <= cfg_data[SL_W-1:0];
				dsba_pkg::REG_SHADER_VIS: shader_vis_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			handle_q    <= '0;
			slot_in_q   <= '0;
			scan_up_q   <= 1'b0;
			scan_wi_q   <= '0;
			scan_left_q <= '0;
			pend_s1     <= 1'b0;
			pend_wi_s1  <= '0;
			wa_q        <= '0;
			bit_q       <= '0;
			set_q       <= 1'b0;
			wword_q     <= '0;
			slot_q      <= '0;
			prod_q      <= '0;
			lt_q        <= 1'b0;
			off_q       <= '0;
			lim_q       <= '0;
			div_start_q <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= '0;
			slot_out_q  <= '0;
			cpu_q       <= '0;
			gpu_q       <= '0;
		end else begin
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start && mem_ready) begin
						op_q      <= op;
						handle_q  <= handle;
						slot_in_q <= slot_in;
						state_q   <= S_DISP;
					end
				end

				// Set up the work for the request code.
				S_DISP: begin
					pend_s1 <= 1'b0;
					unique case (op_q)
						dsba_pkg::OP_ALLOC, dsba_pkg::OP_FIND_HI: begin
							scan_up_q   <= (op_q == dsba_pkg::OP_ALLOC);
							scan_left_q <= nw;
							scan_wi_q   <= (op_q == dsba_pkg::OP_ALLOC) ? '0 :
								dsba_pkg::WI_W'(nw - 1'b1);
							state_q     <= S_SCAN;
						end
						dsba_pkg::OP_FREE, dsba_pkg::OP_INDEX: begin
							lt_q    <= handle_q < base;
							off_q   <= handle_q - base;
							lim_q   <= DW'(stride) * DW'(n);
							state_q <= S_RCHK;
						end
						dsba_pkg::OP_RESERVE: begin
							if (SL_W'(slot_in_q) < n) begin
								wa_q    <= AW'(slot_in_q[dsba_pkg::PSLOT_W-1:dsba_pkg::BIT_W]);
								bit_q   <= slot_in_q[dsba_pkg::BIT_W-1:0];
								set_q   <= 1'b1;
								slot_q  <= SL_W'(slot_in_q);
								state_q <= S_RMW_RD;
							end else begin
								status_q   <= dsba_pkg::ST_RANGE;
								slot_out_q <= slot_in_q;
								cpu_q      <= '0;
								gpu_q      <= '0;
								done_q     <= 1'b1;
								state_q    <= S_IDLE;
							end
						end
						default: begin
							status_q   <= dsba_pkg::ST_OK;
							slot_out_q <= '0;
							cpu_q      <= '0;
							gpu_q      <= '0;
							done_q     <= 1'b1;
							state_q    <= S_IDLE;
						end
					endcase
				end

				// Read one word per cycle and test the word read the cycle before.
				S_SCAN: begin
					if (hit) begin
						pend_s1 <= 1'b0;
						if (scan_up_q) begin
							slot_q  <= {pend_wi_s1, lo_bit};
							wa_q    <= AW'(pend_wi_s1);
							wword_q <= mem_rdata | (WW'(1) << lo_bit);
							state_q <= S_WB;
						end else begin
							status_q   <= dsba_pkg::ST_OK;
							slot_out_q <= dsba_pkg::PSLOT_W'({pend_wi_s1, hi_bit});
							cpu_q      <= '0;
							gpu_q      <= '0;
							done_q     <= 1'b1;
							state_q    <= S_IDLE;
						end
					end else if (!scan_issue && !pend_s1) begin
						status_q   <= dsba_pkg::ST_FULL;
						slot_out_q <= '0;
						cpu_q      <= '0;
						gpu_q      <= '0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						pend_s1    <= scan_issue;
						pend_wi_s1 <= scan_wi_q;
						if (scan_issue) begin
							scan_left_q <= scan_left_q - 1'b1;
							scan_wi_q   <= scan_up_q ? scan_wi_q + 1'b1 : scan_wi_q - 1'b1;
						end
					end
				end

				// Mark the allocated slot and scale it by the stride.
				S_WB: begin
					prod_q  <= DW'(stride) * DW'(slot_q);
					state_q <= S_ADDR;
				end

				// Add the bases to form the handles; the GPU handle is zero unless shader visible.
				S_ADDR: begin
					status_q   <= dsba_pkg::ST_OK;
					slot_out_q <= dsba_pkg::PSLOT_W'(slot_q);
					cpu_q      <= cpu_base_q + HW'(prod_q);
					gpu_q      <= shader_vis_q ? gpu_base_q + HW'(prod_q) : '0;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end

				// Range check: base <= handle < base + stride * count.
				S_RCHK: begin
					if (lt_q || (off_q >= HW'(lim_q))) begin
						status_q   <= dsba_pkg::ST_RANGE;
						slot_out_q <= '0;
						cpu_q      <= '0;
						gpu_q      <= '0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end

				// Wait for the slot number from the divider.
				S_DIV: begin
					if (div_done) begin
						if (op_q == dsba_pkg::OP_FREE) begin
							wa_q    <= AW'(div_quo[SL_W-1:dsba_pkg::BIT_W]);
							bit_q   <= div_quo[dsba_pkg::BIT_W-1:0];
							set_q   <= 1'b0;
							slot_q  <= div_quo;
							state_q <= S_RMW_RD;
						end else begin
							status_q   <= dsba_pkg::ST_OK;
							slot_out_q <= dsba_pkg::PSLOT_W'(div_quo);
							cpu_q      <= '0;
							gpu_q      <= '0;
							done_q     <= 1'b1;
							state_q    <= S_IDLE;
						end
					end
				end

				S_RMW_RD: begin
					state_q <= S_RMW_WR;
				end

				// Write back the word with the slot bit set or cleared.
				S_RMW_WR: begin
					status_q   <= dsba_pkg::ST_OK;
					slot_out_q <= dsba_pkg::PSLOT_W'(slot_q);
					cpu_q      <= '0;
					gpu_q      <= '0;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE) || !mem_ready;
	assign done       = done_q;
	assign status     = status_q;
	assign slot_out   = slot_out_q;
	assign cpu_handle = cpu_q;
	assign gpu_handle = gpu_q;

endmodule

>>> rtl/dsba_checker.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator port checker
// Watches the request and result ports for sequencing and result
// consistency errors.
// ----------------------------------------------------------------------------
module dsba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [dsba_pkg::ST_W-1:0]     status,
	input logic [dsba_pkg::HANDLE_W-1:0] cpu_handle,
	input logic [dsba_pkg::HANDLE_W-1:0] gpu_handle
);

	// A taken request keeps the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but block not busy");

	// A result only follows a cycle of work.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	// Each request gives a single result strobe.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// Failed requests carry no handles, and the status code is defined.
	a_err_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != dsba_pkg::ST_OK)) |->
		((cpu_handle == '0) && (gpu_handle == '0) &&
		((status == dsba_pkg::ST_FULL) || (status == dsba_pkg::ST_RANGE))))
		else $error("bad status or handles on a failed request");

endmodule

bind descriptor_slot_bitmap_allocator dsba_checker u_dsba_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.cpu_handle (cpu_handle),
	.gpu_handle (gpu_handle)
);
